### rtl/svpwm_min_max_injection_assert.svh
`ifndef SVPWM_MIN_MAX_INJECTION_ASSERT_SVH
`define SVPWM_MIN_MAX_INJECTION_ASSERT_SVH

// Checks a property on the rising clock edge, ignored while reset is low.
`define SVPWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on the rising clock edge, reset included.
`define SVPWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/svpwm_pkg.sv
package svpwm_pkg;

  localparam int FieldW = 16;
  localparam int ScaleW = 17;
  localparam int SampleBitsDef = 16;
  localparam logic [ScaleW-1:0] ScaleReset = 17'h10000;
  localparam int DutyMax = 65535;

  typedef logic [ScaleW-1:0] scale_t;
  typedef logic [FieldW-1:0] duty_t;

  // Rounded integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt_round(logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] bits;
    rem = x;
    r = '0;
    bits = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bits) begin
        rem = rem - (r + bits);
        r = (r >> 1) + bits;
      end else begin
        r = r >> 1;
      end
      bits = bits >> 2;
    end
    if (x - r * r > r) begin
      r = r + 64'd1;
    end
    return r;
  endfunction

  // Coefficient sqrt(3)/2 with s fraction bits, rounded to nearest.
  function automatic logic [63:0] sqrt3_half(int s);
    return isqrt_round(64'd3 << (2 * s - 2));
  endfunction

endpackage

### rtl/svpwm_min_max_injection.sv
// Space-vector PWM duty generator with min/max zero-sequence injection.
// Input channel: one item is a (v_alpha_i, v_beta_i) pair in signed Q1.15,
// accepted when in_valid_i and in_ready_o are both high.
// Output channel: one item is the three unsigned Q0.16 duties duty_a_o,
// duty_b_o and duty_c_o, taken when out_valid_o and out_ready_i are high.
// The cfg_we_i/cfg_wdata_i port writes the 17-bit Q1.16 output scale;
// write it only while no item is in flight.
// The datapath is a six-stage pipeline: multiply by sqrt(3)/2, phase sums,
// min/max, injection and clamp, scale partial products, final sum and
// saturation. Each item passes through these stages in that order, and one
// item can be accepted in every cycle while out_ready_i stays high.
// Each stage holds its item while the stage after it is full and held, so
// a stalled receiver fills the pipeline bubbles first and then deasserts
// in_ready_o; nothing is dropped or repeated.
// Reset empties the pipeline and sets the output scale to 65536 (full).
module svpwm_min_max_injection
  import svpwm_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [FieldW-1:0] v_alpha_i,
  input  logic signed [FieldW-1:0] v_beta_i,
  input  logic                     cfg_we_i,
  input  logic [ScaleW-1:0]        cfg_wdata_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [FieldW-1:0]        duty_a_o,
  output logic [FieldW-1:0]        duty_b_o,
  output logic [FieldW-1:0]        duty_c_o
);

  localparam int S    = SAMPLE_BITS;
  localparam int NSt  = 6;
  localparam int PW   = S + 17;
  localparam int DW   = S + 20;
  localparam int DuW  = S + 17;
  localparam int LoW  = S + ScaleW;
  localparam int HiW  = 2 * ScaleW;
  localparam int SumW = HiW + 1;
  localparam int QW   = SumW - 16;
  localparam logic signed [PW-1:0] K = PW'(sqrt3_half(S));
  localparam logic signed [DW-1:0] Offset = DW'(1) <<< (15 + S);
  localparam logic signed [DW-1:0] Top = DW'(1) <<< (16 + S);

  logic [NSt-1:0] valid_q;
  logic [NSt:0]   rdy;
  logic [NSt-1:0] en;

  scale_t scale_q;

  logic signed [PW-1:0] a_q, bk_q, bk_d;
  logic signed [PW-1:0] ph1_q [3];
  logic signed [PW-1:0] ph1_d [3];
  logic signed [PW-1:0] ph2_q [3];
  logic signed [PW-1:0] lo_q, hi_q, lo_d, hi_d;
  logic [DuW-1:0]       du_q [3];
  logic [DuW-1:0]       du_d [3];
  logic [HiW-1:0]       pph_q [3];
  logic [HiW-1:0]       pph_d [3];
  logic [ScaleW-1:0]    ppl_q [3];
  logic [ScaleW-1:0]    ppl_d [3];
  duty_t                duty_q [3];
  duty_t                duty_d [3];

  function automatic logic [DuW-1:0] inject(logic signed [PW-1:0] p,
                                            logic signed [PW-1:0] lo,
                                            logic signed [PW-1:0] hi);
    logic signed [DW-1:0] d;
    logic [DuW-1:0]       r;
    d = (DW'(p) <<< 1) - DW'(lo) - DW'(hi) + Offset;
    if (d < 0) begin
      r = '0;
    end else if (d > Top) begin
      r = DuW'(Top);
    end else begin
      r = DuW'(d);
    end
    return r;
  endfunction

  function automatic duty_t finish(logic [HiW-1:0] ph, logic [ScaleW-1:0] pl);
    logic [SumW-1:0] sum;
    logic [QW-1:0]   q;
    sum = SumW'(ph) + SumW'(pl);
    q = sum[SumW-1:16];
    return (|q[QW-1:FieldW]) ? duty_t'(DutyMax) : q[FieldW-1:0];
  endfunction

  always_comb begin
    rdy[NSt] = out_ready_i;
    for (int i = NSt - 1; i >= 0; i--) begin
      rdy[i] = !valid_q[i] || rdy[i+1];
    end
    en[0] = rdy[0] && in_valid_i;
    for (int i = 1; i < NSt; i++) begin
      en[i] = rdy[i] && valid_q[i-1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NSt-1];
  assign duty_a_o    = duty_q[0];
  assign duty_b_o    = duty_q[1];
  assign duty_c_o    = duty_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      scale_q <= ScaleReset;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NSt; i++) begin
        if (rdy[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  assign bk_d = PW'(v_beta_i) * K;

  always_comb begin
    logic signed [PW-1:0] half;
    half = a_q <<< (S - 1);
    ph1_d[0] = a_q <<< S;
    ph1_d[1] = bk_q - half;
    ph1_d[2] = -half - bk_q;
  end

  always_comb begin
    lo_d = ph1_q[0];
    hi_d = ph1_q[0];
    for (int i = 1; i < 3; i++) begin
      if (ph1_q[i] < lo_d) begin
        lo_d = ph1_q[i];
      end
      if (ph1_q[i] > hi_d) begin
        hi_d = ph1_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      du_d[i]   = inject(ph2_q[i], lo_q, hi_q);
      pph_d[i]  = HiW'(du_q[i][DuW-1:S]) * HiW'(scale_q);
      ppl_d[i]  = ScaleW'((LoW'(du_q[i][S-1:0]) * LoW'(scale_q)) >> S);
      duty_d[i] = finish(pph_q[i], ppl_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q  <= PW'(v_alpha_i);
      bk_q <= bk_d;
    end
    if (en[1]) begin
      ph1_q <= ph1_d;
    end
    if (en[2]) begin
      ph2_q <= ph1_q;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
    end
    if (en[3]) begin
      du_q <= du_d;
    end
    if (en[4]) begin
      pph_q <= pph_d;
      ppl_q <= ppl_d;
    end
    if (en[5]) begin
      duty_q <= duty_d;
    end
  end

`include "svpwm_min_max_injection_assert.svh"

  logic mm_ok;
  logic du_ok;

  assign mm_ok = (lo_q <= hi_q) && (lo_q <= ph2_q[1]) && (ph2_q[1] <= hi_q)
                 && (lo_q <= ph2_q[2]) && (ph2_q[2] <= hi_q);
  assign du_ok = !du_q[0][DuW-1] || (du_q[0][DuW-2:0] == '0);

  `SVPWM_ASSERT(a_empty_ready, !(|valid_q) |-> in_ready_o, "Empty pipeline refuses an item.")
  `SVPWM_ASSERT(a_accept_enters, in_valid_i && in_ready_o |=> valid_q[0], "Item lost at entry.")
  `SVPWM_ASSERT(a_min_max_order, valid_q[2] |-> mm_ok, "Phase outside min/max range.")
  `SVPWM_ASSERT(a_duty_clamped, valid_q[3] |-> du_ok, "Clamped duty exceeds one.")

endmodule
